@@ src/cau_pkg.sv @@
// cau_pkg: shared types and constants for the complex arithmetic unit
// opcode and status codes, operation classes, parameter defaults; no dependencies
`timescale 1ns / 1ps

package cau_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // opcodes on func
  localparam logic [2:0] FN_MUL   = 3'd0;
  localparam logic [2:0] FN_SCALE = 3'd1;
  localparam logic [2:0] FN_DIV   = 3'd2;
  localparam logic [2:0] FN_ADD   = 3'd3;
  localparam logic [2:0] FN_SUB   = 3'd4;
  localparam logic [2:0] FN_NEG   = 3'd5;
  localparam logic [2:0] FN_SQRT  = 3'd6;
  localparam logic [2:0] FN_NONE  = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // operation class decided by the front end
  typedef enum logic [3:0] {
    OP_MUL,
    OP_SCALE,
    OP_DIV,
    OP_DIVZ,
    OP_ADD,
    OP_SUB,
    OP_NEG,
    OP_SQRT,
    OP_NONE
  } op_e;

endpackage

@@ src/cau_front.sv @@
// cau_front: accepts items, classifies the opcode and holds them in a two-entry queue
// depends on cau_pkg
`timescale 1ns / 1ps

module cau_front #(
  parameter int unsigned W = cau_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          func_i,
  input  logic [W-1:0]        a_re_i,
  input  logic [W-1:0]        a_im_i,
  input  logic [W-1:0]        b_re_i,
  input  logic [W-1:0]        b_im_i,
  input  logic [W-1:0]        scalar_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output cau_pkg::op_e        q_op_o,
  output logic [5*W-1:0]      q_data_o
);
  import cau_pkg::*;

  op_e            ent_op_q  [2];
  logic [5*W-1:0] ent_dat_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push;
  op_e            op_cls;

  always_comb begin
    unique case (func_i)
      FN_MUL:   op_cls = OP_MUL;
      FN_SCALE: op_cls = OP_SCALE;
      // zero divisor is settled here, the back end only outputs zero
      FN_DIV:   op_cls = (b_re_i == '0 && b_im_i == '0) ? OP_DIVZ : OP_DIV;
      FN_ADD:   op_cls = OP_ADD;
      FN_SUB:   op_cls = OP_SUB;
      FN_NEG:   op_cls = OP_NEG;
      FN_SQRT:  op_cls = OP_SQRT;
      FN_NONE:  op_cls = OP_NONE;
      default:  op_cls = OP_NONE;
    endcase
  end

  assign busy      = (cnt_q == 2'd2);
  assign push      = start && !busy;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_op_o    = ent_op_q[rd_ptr_q];
  assign q_data_o  = ent_dat_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_op_q[wr_ptr_q]  <= op_cls;
      ent_dat_q[wr_ptr_q] <= {scalar_i, b_im_i, b_re_i, a_im_i, a_re_i};
    end
  end

endmodule

@@ src/cau_back.sv @@
// cau_back: carries out one queued item: shared multiplier, bit-serial divider
// and digit-by-digit square root, then saturation; depends on cau_pkg
`timescale 1ns / 1ps

module cau_back #(
  parameter int unsigned W = cau_pkg::DATA_WIDTH_DEF,
  parameter int unsigned F = cau_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  cau_pkg::op_e   q_op_i,
  input  logic [5*W-1:0] q_data_i,
  output logic           done_o,
  output logic [W-1:0]   res_re_o,
  output logic [W-1:0]   res_im_o,
  output logic [1:0]     status_o
);
  import cau_pkg::*;

  localparam int unsigned AW     = 2 * W + 2;
  localparam int unsigned MW     = 2 * W + 2 + F;
  localparam int unsigned SN_RAW = (2 * W > W + F) ? 2 * W : W + F;
  localparam int unsigned SN     = SN_RAW + (SN_RAW % 2);
  localparam int unsigned RN     = SN / 2;
  localparam int unsigned VW     = SN + 1;
  localparam int unsigned CW     = $clog2(MW + 1);

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_DIV, S_SQ0, S_SQ1, S_FIN} state_e;
  typedef enum logic [1:0] {T_RE, T_IM, T_M} tgt_e;

  state_e                state_q;
  op_e                   op_q;
  logic signed [W-1:0]   ar_q, ai_q, br_q, bi_q, sc_q;
  logic [2:0]            step_q;
  logic signed [2*W-1:0] p_q;
  logic                  p_vld_q, p_sub_q;
  tgt_e                  p_tgt_q;
  logic signed [AW-1:0]  acc_re_q, acc_im_q, acc_m_q;
  logic [CW-1:0]         cnt_q;
  logic [2*W:0]          drem_re_q, drem_im_q;
  logic [MW-1:0]         dq_re_q, dq_im_q;
  logic                  re_neg_q, im_neg_q;
  logic [SN-1:0]         sop0_q, sop1_q;
  logic [RN:0]           srem0_q, srem1_q;
  logic [RN-1:0]         sroot0_q, sroot1_q;
  logic                  done_q;
  logic [W-1:0]          res_re_q, res_im_q;
  logic [1:0]            status_q;

  logic [2:0]            nsteps;
  logic signed [W-1:0]   mx, my;
  tgt_e                  mtgt;
  logic                  msub;
  logic signed [AW-1:0]  pext;
  logic [2*W+1:0]        dstep_re, dstep_im;
  logic [2*RN:0]         sstep0, sstep1;
  logic [VW-1:0]         v1, v2;
  logic signed [AW-1:0]  addsub;
  logic [W:0]            sat_re, sat_im;
  logic                  mac_done;

  function automatic logic [MW-1:0] abs_mw(input logic signed [AW-1:0] v);
    logic [AW-1:0] u;
    u = v[AW-1] ? AW'(-v) : AW'(v);
    return MW'(u);
  endfunction

  // returns {overflow, value}
  function automatic logic [W:0] sat_sm(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] half;
    logic [W-1:0]  low;
    half = MW'(1) << (W - 1);
    low  = mag[W-1:0];
    if (!neg && mag >= half) begin
      return {1'b1, 1'b0, {(W-1){1'b1}}};
    end else if (neg && mag > half) begin
      return {1'b1, 1'b1, {(W-1){1'b0}}};
    end else if (neg) begin
      return {1'b0, W'(~low + W'(1))};
    end else begin
      return {1'b0, low};
    end
  endfunction

  // restoring division step: {quotient bit, new remainder}
  function automatic logic [2*W+1:0] div_step(input logic [2*W:0] rem, input logic din,
                                              input logic [2*W:0] m);
    logic [2*W+1:0] r2, d;
    r2 = {rem, din};
    d  = r2 - {1'b0, m};
    if (r2 >= {1'b0, m}) begin
      return {1'b1, d[2*W:0]};
    end else begin
      return {1'b0, r2[2*W:0]};
    end
  endfunction

  // square root digit step: {new remainder, new root}
  function automatic logic [2*RN:0] sq_step(input logic [RN:0] rem, input logic [RN-1:0] root,
                                            input logic [1:0] two);
    logic [RN+2:0] r2, trial, d;
    r2    = {rem, two};
    trial = {1'b0, root, 2'b01};
    d     = r2 - trial;
    if (r2 >= trial) begin
      return {d[RN:0], root[RN-2:0], 1'b1};
    end else begin
      return {r2[RN:0], root[RN-2:0], 1'b0};
    end
  endfunction

  always_comb begin
    unique case (op_q)
      OP_MUL:   nsteps = 3'd4;
      OP_SCALE: nsteps = 3'd2;
      OP_DIV:   nsteps = 3'd6;
      OP_SQRT:  nsteps = 3'd2;
      default:  nsteps = 3'd0;
    endcase
  end

  // product schedule: operands, target accumulator and sign
  always_comb begin
    mx   = '0;
    my   = '0;
    mtgt = T_RE;
    msub = 1'b0;
    unique case (op_q)
      OP_MUL: begin
        case (step_q)
          3'd0:    begin mx = ar_q; my = br_q; end
          3'd1:    begin mx = ai_q; my = bi_q; msub = 1'b1; end
          3'd2:    begin mx = ar_q; my = bi_q; mtgt = T_IM; end
          default: begin mx = ai_q; my = br_q; mtgt = T_IM; end
        endcase
      end
      OP_SCALE: begin
        if (step_q == 3'd0) begin
          mx = sc_q; my = ar_q;
        end else begin
          mx = sc_q; my = ai_q; mtgt = T_IM;
        end
      end
      OP_DIV: begin
        case (step_q)
          3'd0:    begin mx = ar_q; my = br_q; end
          3'd1:    begin mx = ai_q; my = bi_q; end
          3'd2:    begin mx = ai_q; my = br_q; mtgt = T_IM; end
          3'd3:    begin mx = ar_q; my = bi_q; mtgt = T_IM; msub = 1'b1; end
          3'd4:    begin mx = br_q; my = br_q; mtgt = T_M; end
          default: begin mx = bi_q; my = bi_q; mtgt = T_M; end
        endcase
      end
      OP_SQRT: begin
        mtgt = T_M;
        if (step_q == 3'd0) begin
          mx = ar_q; my = ar_q;
        end else begin
          mx = ai_q; my = ai_q;
        end
      end
      default: begin
        mx = '0;
      end
    endcase
  end

  assign pext     = p_sub_q ? -AW'(p_q) : AW'(p_q);
  assign mac_done = (step_q == nsteps) && !p_vld_q;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;

  assign dstep_re = div_step(drem_re_q, dq_re_q[MW-1], acc_m_q[2*W:0]);
  assign dstep_im = div_step(drem_im_q, dq_im_q[MW-1], acc_m_q[2*W:0]);
  assign sstep0   = sq_step(srem0_q, sroot0_q, sop0_q[SN-1:SN-2]);
  assign sstep1   = sq_step(srem1_q, sroot1_q, sop1_q[SN-1:SN-2]);

  // half-angle operands from the finished first root: r + a_re and r - a_re, both nonnegative
  assign v1 = VW'(sstep0[RN-1:0]) + VW'(ar_q);
  assign v2 = VW'(sstep0[RN-1:0]) - VW'(ar_q);

  // final values
  always_comb begin
    addsub = '0;
    sat_re = '0;
    sat_im = '0;
    unique case (op_q)
      OP_MUL, OP_SCALE: begin
        sat_re = sat_sm(acc_re_q[AW-1], abs_mw(acc_re_q) >> F);
        sat_im = sat_sm(acc_im_q[AW-1], abs_mw(acc_im_q) >> F);
      end
      OP_DIV: begin
        sat_re = sat_sm(re_neg_q, dq_re_q);
        sat_im = sat_sm(im_neg_q, dq_im_q);
      end
      OP_ADD: begin
        addsub = AW'(ar_q) + AW'(br_q);
        sat_re = sat_sm(addsub[AW-1], abs_mw(addsub));
        addsub = AW'(ai_q) + AW'(bi_q);
        sat_im = sat_sm(addsub[AW-1], abs_mw(addsub));
      end
      OP_SUB: begin
        addsub = AW'(ar_q) - AW'(br_q);
        sat_re = sat_sm(addsub[AW-1], abs_mw(addsub));
        addsub = AW'(ai_q) - AW'(bi_q);
        sat_im = sat_sm(addsub[AW-1], abs_mw(addsub));
      end
      OP_NEG: begin
        addsub = -AW'(ar_q);
        sat_re = sat_sm(addsub[AW-1], abs_mw(addsub));
        addsub = -AW'(ai_q);
        sat_im = sat_sm(addsub[AW-1], abs_mw(addsub));
      end
      OP_SQRT: begin
        sat_re = sat_sm(1'b0, MW'(sroot0_q));
        sat_im = sat_sm(ai_q[W-1], MW'(sroot1_q));
      end
      default: begin
        sat_re = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      p_vld_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_FIN);
      unique case (state_q)
        S_IDLE: begin
          p_vld_q <= 1'b0;
          if (q_valid_i) begin
            unique case (q_op_i)
              OP_MUL, OP_SCALE, OP_DIV, OP_SQRT: state_q <= S_MAC;
              default:                           state_q <= S_FIN;
            endcase
          end
        end
        S_MAC: begin
          p_vld_q <= (step_q != nsteps);
          if (mac_done) begin
            unique case (op_q)
              OP_DIV:  state_q <= S_DIV;
              OP_SQRT: state_q <= S_SQ0;
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_DIV: begin
          if (cnt_q == CW'(1)) begin
            state_q <= S_FIN;
          end
        end
        S_SQ0: begin
          if (cnt_q == CW'(1)) begin
            state_q <= S_SQ1;
          end
        end
        S_SQ1: begin
          if (cnt_q == CW'(1)) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        op_q     <= q_op_i;
        ar_q     <= q_data_i[W-1:0];
        ai_q     <= q_data_i[2*W-1:W];
        br_q     <= q_data_i[3*W-1:2*W];
        bi_q     <= q_data_i[4*W-1:3*W];
        sc_q     <= q_data_i[5*W-1:4*W];
        step_q   <= '0;
        acc_re_q <= '0;
        acc_im_q <= '0;
        acc_m_q  <= '0;
      end
      S_MAC: begin
        if (step_q != nsteps) begin
          p_q     <= mx * my;
          p_tgt_q <= mtgt;
          p_sub_q <= msub;
          step_q  <= step_q + 3'd1;
        end
        if (p_vld_q) begin
          unique case (p_tgt_q)
            T_RE:    acc_re_q <= acc_re_q + pext;
            T_IM:    acc_im_q <= acc_im_q + pext;
            default: acc_m_q  <= acc_m_q + pext;
          endcase
        end
        if (mac_done) begin
          // load the divider or the first root from the finished sums
          dq_re_q   <= abs_mw(acc_re_q) << F;
          dq_im_q   <= abs_mw(acc_im_q) << F;
          re_neg_q  <= acc_re_q[AW-1];
          im_neg_q  <= acc_im_q[AW-1];
          drem_re_q <= '0;
          drem_im_q <= '0;
          sop0_q    <= SN'(acc_m_q[2*W-1:0]);
          srem0_q   <= '0;
          sroot0_q  <= '0;
          cnt_q     <= (op_q == OP_DIV) ? CW'(MW) : CW'(RN);
        end
      end
      S_DIV: begin
        drem_re_q <= dstep_re[2*W:0];
        drem_im_q <= dstep_im[2*W:0];
        dq_re_q   <= {dq_re_q[MW-2:0], dstep_re[2*W+1]};
        dq_im_q   <= {dq_im_q[MW-2:0], dstep_im[2*W+1]};
        cnt_q     <= cnt_q - CW'(1);
      end
      S_SQ0: begin
        if (cnt_q == CW'(1)) begin
          // the last first-root step also loads both half-angle roots
          srem0_q  <= '0;
          sroot0_q <= '0;
          srem1_q  <= '0;
          sroot1_q <= '0;
          sop0_q   <= SN'((v1 << F) >> 1);
          sop1_q   <= SN'((v2 << F) >> 1);
          cnt_q    <= CW'(RN);
        end else begin
          srem0_q  <= sstep0[2*RN:RN];
          sroot0_q <= sstep0[RN-1:0];
          sop0_q   <= sop0_q << 2;
          cnt_q    <= cnt_q - CW'(1);
        end
      end
      S_SQ1: begin
        srem0_q  <= sstep0[2*RN:RN];
        sroot0_q <= sstep0[RN-1:0];
        sop0_q   <= sop0_q << 2;
        srem1_q  <= sstep1[2*RN:RN];
        sroot1_q <= sstep1[RN-1:0];
        sop1_q   <= sop1_q << 2;
        cnt_q    <= cnt_q - CW'(1);
      end
      S_FIN: begin
        res_re_q <= sat_re[W-1:0];
        res_im_q <= sat_im[W-1:0];
        if (op_q == OP_DIVZ) begin
          status_q <= ST_DIVZ;
        end else if (sat_re[W] || sat_im[W]) begin
          status_q <= ST_SAT;
        end else begin
          status_q <= ST_OK;
        end
      end
      default: begin
        step_q <= '0;
      end
    endcase
  end

  assign done_o   = done_q;
  assign res_re_o = res_re_q;
  assign res_im_o = res_im_q;
  assign status_o = status_q;

endmodule

@@ src/complex_arithmetic_unit.sv @@
// complex_arithmetic_unit: complex Q-format multiply, scale, divide, add, subtract,
// negate and square root; front queue (cau_front) feeds the execution unit (cau_back)
// add/sub/neg/zero divide go straight to the result register; multiply and scale use
// the shared multiplier; divide and sqrt then run the bit-serial divider or root steps
// the back end takes one item at a time; items queue two deep, busy while full
// reset clears the queue and sequencer; done_o pulses one cycle per result, never held
`timescale 1ns / 1ps

module complex_arithmetic_unit #(
  parameter int unsigned DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            func_i,
  input  logic [DATA_WIDTH-1:0] a_re_i,
  input  logic [DATA_WIDTH-1:0] a_im_i,
  input  logic [DATA_WIDTH-1:0] b_re_i,
  input  logic [DATA_WIDTH-1:0] b_im_i,
  input  logic [DATA_WIDTH-1:0] scalar_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] res_re_o,
  output logic [DATA_WIDTH-1:0] res_im_o,
  output logic [1:0]            status_o
);
  import cau_pkg::*;

  logic                    q_valid, q_pop;
  op_e                     q_op;
  logic [5*DATA_WIDTH-1:0] q_data;

  cau_front #(
    .W (DATA_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .func_i    (func_i),
    .a_re_i    (a_re_i),
    .a_im_i    (a_im_i),
    .b_re_i    (b_re_i),
    .b_im_i    (b_im_i),
    .scalar_i  (scalar_i),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_op_o    (q_op),
    .q_data_o  (q_data)
  );

  cau_back #(
    .W (DATA_WIDTH),
    .F (FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_op_i    (q_op),
    .q_data_i  (q_data),
    .done_o    (done_o),
    .res_re_o  (res_re_o),
    .res_im_o  (res_im_o),
    .status_o  (status_o)
  );

endmodule
